// File: rtl/dtpd_pkg.sv
`default_nettype none

package dtpd_pkg;

	// sizing
	localparam int DEF_CHANNELS = 4;
	localparam int PREGAIN_REGS = 4;
	localparam int QUEUE_DEPTH  = 2;

	// reset values of the register file
	localparam logic [15:0] HOLDOFF_RST = 16'd1000;
	localparam logic [7:0]  GAIN_RST    = 8'd100;
	localparam logic [7:0]  DEVICE_RST  = 8'd0;

	// arithmetic constants
	localparam logic [15:0] THR_STEP   = 16'd328;    // 0.01 in q1.15
	localparam logic [15:0] GAIN_SCALE = 16'd50000;  // percent * percent * 5
	localparam logic [16:0] UNITY      = 17'd32768;  // 1.0 in q1.15
	localparam logic [6:0]  VEL_MAX    = 7'd127;

	typedef enum logic [2:0] {
		REG_PAUSED  = 3'd0,
		REG_HOLDOFF = 3'd1,
		REG_MASTER  = 3'd2,
		REG_DEVICE  = 3'd3,
		REG_PRE0    = 3'd4,
		REG_PRE1    = 3'd5,
		REG_PRE2    = 3'd6,
		REG_PRE3    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic                             paused;
		logic [15:0]                      holdoff;
		logic [7:0]                       master;
		logic [7:0]                       device;
		logic [PREGAIN_REGS-1:0][7:0]     pre_gain;
	} cfg_t;

	// one pending hit handed from the front to the back
	typedef struct packed {
		logic [1:0]  chan;
		logic [15:0] peak;
		logic [14:0] thr;
	} job_t;

	typedef enum logic {
		F_IDLE,
		F_CALC
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL1,
		B_MUL2,
		B_NUM,
		B_CLAMP,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/audio_drum_trigger_peak_detect.sv
// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------------
// in       | in_valid / in_stall     | chan_index, sample_value, learn_mode
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
// out      | out_valid / out_stall   | trig_device, trig_channel, trig_velocity
//
// the front takes a sample only once the last is done: accept with the channel state read,
// then update and write back through the single channel state memory port
// a firing hit leaves the back early when the numerator is nonpositive, skips the divide
// when the velocity clamps, else runs the 7-step restoring divide, then waits out any
// output stall; a 2-entry queue absorbs bursts
// reset is asynchronous; channel state reads as zero via per-channel valid bits,
// so there is no clearing pass and samples are taken right after reset
// out_stall holds the result register; the back stalls behind it with a new result,
// and the front only once the queue fills
`default_nettype none

module audio_drum_trigger_peak_detect #(
	parameter int CHANNELS = dtpd_pkg::DEF_CHANNELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  chan_index,
	input  wire logic [15:0] sample_value,
	input  wire logic        learn_mode,
	// register write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// trigger channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       trig_device,
	output logic [1:0]       trig_channel,
	output logic [6:0]       trig_velocity
);
	import dtpd_pkg::*;

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic q_full;
	logic q_pop;
	job_t q_job;
	logic q_empty;

	// writes are always taken, one register per transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.paused   <= 1'b0;
			cfg_q.holdoff  <= HOLDOFF_RST;
			cfg_q.master   <= GAIN_RST;
			cfg_q.device   <= DEVICE_RST;
			cfg_q.pre_gain <= {PREGAIN_REGS{GAIN_RST}};
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_PAUSED:  cfg_q.paused      <= cfg_data[0];
				REG_HOLDOFF: cfg_q.holdoff     <= cfg_data;
				REG_MASTER:  cfg_q.master      <= cfg_data[7:0];
				REG_DEVICE:  cfg_q.device      <= cfg_data[7:0];
				REG_PRE0:    cfg_q.pre_gain[0] <= cfg_data[7:0];
				REG_PRE1:    cfg_q.pre_gain[1] <= cfg_data[7:0];
				REG_PRE2:    cfg_q.pre_gain[2] <= cfg_data[7:0];
				REG_PRE3:    cfg_q.pre_gain[3] <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// front: rectify, learn threshold, track peak and hold-off, classify hits
	dtpd_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.chan_index   (chan_index),
		.sample_value (sample_value),
		.learn_mode   (learn_mode),
		.cfg          (cfg_q),
		.push         (push),
		.push_job     (push_job),
		.q_full       (q_full)
	);

	// pending hits between front and back
	dtpd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (q_job),
		.empty    (q_empty)
	);

	// back: gain scaling and velocity division
	dtpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_job         (q_job),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.trig_device   (trig_device),
		.trig_channel  (trig_channel),
		.trig_velocity (trig_velocity)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("hit pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("hit popped from an empty queue");

	a_vel_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (trig_velocity != '0))
		else $error("trigger with zero velocity");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({30'b0, trig_channel} < 32'(CHANNELS)))
		else $error("trigger on a channel beyond the configured count");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("front took a sample while updating the previous one");

endmodule

`default_nettype wire

// File: rtl/dtpd_front.sv
`default_nettype none

module dtpd_front #(
	parameter int CHANNELS = dtpd_pkg::DEF_CHANNELS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [1:0]     chan_index,
	input  wire logic [15:0]    sample_value,
	input  wire logic           learn_mode,
	input  dtpd_pkg::cfg_t      cfg,
	output logic                push,
	output dtpd_pkg::job_t      push_job,
	input  wire logic           q_full
);
	import dtpd_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef struct packed {
		logic [15:0] thr;
		logic [15:0] peak;
		logic [15:0] cnt;
	} chan_state_t;

	chan_state_t        mem [CHANNELS];
	chan_state_t        rd_q;
	logic [CHANNELS-1:0] valid_q;

	front_state_t state_q, state_d;
	logic [CH_W-1:0] addr_q;
	logic [1:0]      chan_q;
	logic [15:0]     mag_q;
	logic            learn_q;

	logic            accept;
	logic [CH_W-1:0] addr_in;
	logic [15:0]     mag_in;
	chan_state_t     cur;
	chan_state_t     nxt;
	chan_state_t     wr_data;
	logic            chan_ok;
	logic            active;
	logic            above;
	logic [16:0]     thr_sum;
	logic [15:0]     cnt_inc;
	logic            fire;
	logic            need_push;
	logic            go;
	logic            do_write;

	assign accept  = in_valid && !in_stall;
	assign addr_in = CH_W'(chan_index);
	// rectify, full-scale negative becomes 32768
	assign mag_in  = sample_value[15] ? (~sample_value + 16'd1) : sample_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= addr_in;
			chan_q  <= chan_index;
			mag_q   <= mag_in;
			learn_q <= learn_mode;
		end
	end

	// channel state memory, read at accept, written back during F_CALC
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[addr_in];
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[addr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_write) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	always_comb begin
		chan_ok = ({30'b0, chan_q} < 32'(CHANNELS));
		cur     = valid_q[addr_q] ? rd_q : '0;
		above   = mag_q > cur.thr;
		thr_sum = {1'b0, cur.thr} + {1'b0, THR_STEP};
		cnt_inc = (cur.cnt == 16'hFFFF) ? cur.cnt : cur.cnt + 16'd1;

		nxt.thr = cur.thr;
		if (above && learn_q) begin
			nxt.thr = thr_sum[16] ? 16'hFFFF : thr_sum[15:0];
		end
		if (above && (mag_q >= cur.peak)) begin
			nxt.peak = mag_q;
			nxt.cnt  = '0;
		end else begin
			nxt.peak = cur.peak;
			nxt.cnt  = cnt_inc;
		end

		fire      = (nxt.peak != '0) && (nxt.cnt > cfg.holdoff);
		// threshold at or above unity gives no hit, the channel still clears
		need_push = fire && !nxt.thr[15];
		go        = !(need_push && q_full);
		active    = (state_q == F_CALC) && chan_ok && !cfg.paused;
		do_write  = active && go;
		push      = do_write && need_push;

		wr_data = nxt;
		if (fire) begin
			wr_data.peak = '0;
			wr_data.cnt  = '0;
		end

		push_job.chan = chan_q;
		push_job.peak = nxt.peak;
		push_job.thr  = nxt.thr[14:0];
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			F_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = F_CALC;
				end
			end
			F_CALC: begin
				if (!active || go) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/dtpd_fifo.sv
`default_nettype none

module dtpd_fifo (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  dtpd_pkg::job_t push_job,
	output logic           full,
	input  wire logic      pop,
	output dtpd_pkg::job_t pop_job,
	output logic           empty
);
	import dtpd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/dtpd_back.sv
`default_nettype none

module dtpd_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  dtpd_pkg::cfg_t  cfg,
	input  wire logic       q_empty,
	input  dtpd_pkg::job_t  q_job,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      trig_device,
	output logic [1:0]      trig_channel,
	output logic [6:0]      trig_velocity
);
	import dtpd_pkg::*;

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [23:0] p1_q;
	logic [30:0] tp_q;
	logic [30:0] den_q;
	logic [31:0] sc_q;
	logic [38:0] num_q;
	logic [38:0] rem_q;
	logic [36:0] dsh_q;
	logic [6:0]  quo_q;
	logic [2:0]  bit_q;
	logic [6:0]  vel_q;
	logic        out_valid_q;

	logic [31:0] diff;
	logic        ge;
	logic        load_out;
	logic        clamp;

	assign diff  = sc_q - {1'b0, tp_q};
	assign ge    = rem_q >= {2'b0, dsh_q};
	assign clamp = num_q >= {1'b0, den_q, 7'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					job_q <= q_job;
				end
			end
			B_MUL1: begin
				p1_q  <= {8'b0, job_q.peak} * {16'b0, cfg.pre_gain[job_q.chan]};
				tp_q  <= {16'b0, job_q.thr} * {15'b0, GAIN_SCALE};
				den_q <= (31'(UNITY) - {16'b0, job_q.thr}) * {15'b0, GAIN_SCALE};
			end
			B_MUL2: begin
				sc_q <= {8'b0, p1_q} * {24'b0, cfg.master};
			end
			B_NUM: begin
				// 127 * diff as a shift and a subtract
				num_q <= {diff, 7'b0} - {7'b0, diff};
			end
			B_CLAMP: begin
				rem_q <= num_q;
				dsh_q <= {den_q, 6'b0};
				quo_q <= '0;
				bit_q <= 3'd6;
				if (clamp) begin
					vel_q <= VEL_MAX;
				end
			end
			B_DIV: begin
				if (ge) begin
					rem_q <= rem_q - {2'b0, dsh_q};
				end
				dsh_q <= {1'b0, dsh_q[36:1]};
				quo_q <= {quo_q[5:0], ge};
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					vel_q <= {quo_q[5:0], ge};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			trig_device   <= cfg.device;
			trig_channel  <= job_q.chan;
			trig_velocity <= vel_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_MUL1;
				end
			end
			B_MUL1: begin
				state_d = B_MUL2;
			end
			B_MUL2: begin
				state_d = B_NUM;
			end
			B_NUM: begin
				// nonpositive numerator drops the hit
				state_d = (sc_q > {1'b0, tp_q}) ? B_CLAMP : B_IDLE;
			end
			B_CLAMP: begin
				state_d = clamp ? B_OUT : B_DIV;
			end
			B_DIV: begin
				if (bit_q == 3'd0) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (vel_q == '0) begin
					state_d = B_IDLE;
				end else if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
